// ===== rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

   localparam int NumCal  = 6;
   localparam int AddrW   = 5;
   localparam int DivSteps = 32;
   localparam int FrontDepth = 10;
   localparam int BackDepth  = 3;
   localparam int Latency = FrontDepth + DivSteps + BackDepth;

   localparam logic [2:0] REG_T1_T2 = 3'd0;
   localparam logic [2:0] REG_T3_P1 = 3'd1;
   localparam logic [2:0] REG_P2_P3 = 3'd2;
   localparam logic [2:0] REG_P4_P5 = 3'd3;
   localparam logic [2:0] REG_P6_P7 = 3'd4;
   localparam logic [2:0] REG_P8_P9 = 3'd5;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_pascal;
      logic               divide_error;
   } rsp_type;

   typedef struct packed {
      logic [31:0] t1_t2;
      logic [31:0] t3_p1;
      logic [31:0] p2_p3;
      logic [31:0] p4_p5;
      logic [31:0] p6_p7;
      logic [31:0] p8_p9;
   } cal_type;

   // travels alongside the divider
   typedef struct packed {
      logic        valid;
      logic [31:0] temp;
      logic        err;
      logic        dbl;
   } side_type;

   function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] lo_s(input logic [31:0] w);
      return {{16{w[15]}}, w[15:0]};
   endfunction

   function automatic logic [31:0] hi_s(input logic [31:0] w);
      return {{16{w[31]}}, w[31:16]};
   endfunction

   function automatic logic [31:0] lo_u(input logic [31:0] w);
      return {16'd0, w[15:0]};
   endfunction

   function automatic logic [31:0] hi_u(input logic [31:0] w);
      return {16'd0, w[31:16]};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bsc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire bsc_pkg::req_type in_item,
   input  wire bsc_pkg::cal_type cal,
   output logic                  out_valid,
   output logic [31:0]           out_num,
   output logic [31:0]           out_div,
   output logic [31:0]           out_temp
);

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
   assign t1 = bsc_pkg::lo_u(cal.t1_t2);
   assign t2 = bsc_pkg::hi_s(cal.t1_t2);
   assign t3 = bsc_pkg::lo_s(cal.t3_p1);
   assign p1 = bsc_pkg::hi_u(cal.t3_p1);
   assign p2 = bsc_pkg::lo_s(cal.p2_p3);
   assign p3 = bsc_pkg::hi_s(cal.p2_p3);
   assign p4 = bsc_pkg::lo_s(cal.p4_p5);
   assign p5 = bsc_pkg::hi_s(cal.p4_p5);
   assign p6 = bsc_pkg::lo_s(cal.p6_p7);

   logic [bsc_pkg::FrontDepth-1:0] vld_ff;
   logic [19:0] adcp_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[bsc_pkg::FrontDepth-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      adcp_ff[0] <= in_item.raw_pressure;
      for (int i = 1; i < 9; i++) adcp_ff[i] <= adcp_ff[i-1];
   end

   // s1
   logic [31:0] x1_ff, d_ff;
   logic [31:0] adct;
   assign adct = {12'd0, in_item.raw_temperature};
   always_ff @(posedge clock) begin
      x1_ff <= (adct >> 3) - (t1 << 1);
      d_ff  <= (adct >> 4) - t1;
   end

   // s2
   logic [31:0] m1_ff, dd_ff;
   always_ff @(posedge clock) begin
      m1_ff <= x1_ff * t2;
      dd_ff <= d_ff * d_ff;
   end

   // s3
   logic [31:0] at_ff, q_ff;
   always_ff @(posedge clock) begin
      at_ff <= bsc_pkg::sra32(m1_ff, 5'd11);
      q_ff  <= bsc_pkg::sra32(dd_ff, 5'd12) * t3;
   end

   // s4
   logic [31:0] fine_ff;
   always_ff @(posedge clock) begin
      fine_ff <= at_ff + bsc_pkg::sra32(q_ff, 5'd14);
   end

   // s5
   logic [31:0] temp_ff [0:5];
   logic [31:0] a5_ff;
   always_ff @(posedge clock) begin
      temp_ff[0] <= bsc_pkg::sra32((fine_ff << 2) + fine_ff + 32'd128, 5'd8);
      for (int i = 1; i < 6; i++) temp_ff[i] <= temp_ff[i-1];
      a5_ff <= bsc_pkg::sra32(fine_ff, 5'd1) - 32'd64000;
   end

   // s6
   logic [31:0] a2, sq_ff, ma5_ff, pa2_ff;
   assign a2 = bsc_pkg::sra32(a5_ff, 5'd2);
   always_ff @(posedge clock) begin
      sq_ff  <= a2 * a2;
      ma5_ff <= a5_ff * p5;
      pa2_ff <= p2 * a5_ff;
   end

   // s7
   logic [31:0] b0_ff, c0_ff, ma5b_ff, pa2b_ff;
   always_ff @(posedge clock) begin
      b0_ff   <= bsc_pkg::sra32(sq_ff, 5'd11) * p6;
      c0_ff   <= p3 * bsc_pkg::sra32(sq_ff, 5'd13);
      ma5b_ff <= ma5_ff;
      pa2b_ff <= pa2_ff;
   end

   // s8
   logic [31:0] b8_ff, a8_ff;
   always_ff @(posedge clock) begin
      b8_ff <= bsc_pkg::sra32(b0_ff + (ma5b_ff << 1), 5'd2) + (p4 << 16);
      a8_ff <= bsc_pkg::sra32(bsc_pkg::sra32(c0_ff, 5'd3)
                              + bsc_pkg::sra32(pa2b_ff, 5'd1), 5'd18);
   end

   // s9
   logic [31:0] b9_ff, div9_ff;
   always_ff @(posedge clock) begin
      b9_ff   <= b8_ff;
      div9_ff <= bsc_pkg::sra32((32'd32768 + a8_ff) * p1, 5'd15);
   end

   // s10
   logic [31:0] num_ff, div10_ff;
   logic [31:0] base;
   assign base = (32'd1048576 - {12'd0, adcp_ff[8]}) - bsc_pkg::sra32(b9_ff, 5'd12);
   always_ff @(posedge clock) begin
      num_ff   <= base * 32'd3125;
      div10_ff <= div9_ff;
   end

   assign out_valid = vld_ff[bsc_pkg::FrontDepth-1];
   assign out_num   = num_ff;
   assign out_div   = div10_ff;
   assign out_temp  = temp_ff[5];

endmodule
`default_nettype wire

// ===== rtl/bsc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsc_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [31:0]       in_num,
   input  wire logic [31:0]       in_div,
   input  wire logic [31:0]       in_temp,
   output bsc_pkg::side_type      out_side,
   output logic [31:0]            out_quo
);

   localparam int N = bsc_pkg::DivSteps;

   logic [31:0] rem_ff [0:N-1];
   logic [31:0] dvd_ff [0:N-1];
   logic [31:0] quo_ff [0:N-1];
   logic [31:0] dsr_ff [0:N-1];
   bsc_pkg::side_type side_ff [0:N-1];

   logic [31:0] rem_in [0:N-1];
   logic [31:0] dvd_in [0:N-1];
   logic [31:0] quo_in [0:N-1];
   logic [31:0] dsr_in [0:N-1];
   bsc_pkg::side_type side_in [0:N-1];

   logic [31:0] rem_src [0:N-1];
   logic [31:0] dvd_src [0:N-1];
   logic [31:0] quo_src [0:N-1];
   logic [31:0] dsr_src [0:N-1];
   bsc_pkg::side_type side_src [0:N-1];

   always_comb begin
      rem_src[0]        = '0;
      dvd_src[0]        = in_num[31] ? in_num : (in_num << 1);
      quo_src[0]        = '0;
      dsr_src[0]        = in_div;
      side_src[0].valid = in_valid;
      side_src[0].temp  = in_temp;
      side_src[0].err   = (in_div == 32'd0);
      side_src[0].dbl   = in_num[31];
      for (int k = 1; k < N; k++) begin
         rem_src[k]  = rem_ff[k-1];
         dvd_src[k]  = dvd_ff[k-1];
         quo_src[k]  = quo_ff[k-1];
         dsr_src[k]  = dsr_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
   end

   logic [32:0] trial [0:N-1];
   logic [32:0] diff  [0:N-1];

   always_comb begin
      for (int k = 0; k < N; k++) begin
         trial[k]  = {rem_src[k], dvd_src[k][31]};
         diff[k]   = trial[k] - {1'b0, dsr_src[k]};
         dvd_in[k] = dvd_src[k] << 1;
         dsr_in[k] = dsr_src[k];
         side_in[k] = side_src[k];
         if (!diff[k][32]) begin
            rem_in[k] = diff[k][31:0];
            quo_in[k] = {quo_src[k][30:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][31:0];
            quo_in[k] = {quo_src[k][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         rem_ff[k] <= rem_in[k];
         dvd_ff[k] <= dvd_in[k];
         quo_ff[k] <= quo_in[k];
         dsr_ff[k] <= dsr_in[k];
         side_ff[k].temp <= side_in[k].temp;
         side_ff[k].err  <= side_in[k].err;
         side_ff[k].dbl  <= side_in[k].dbl;
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else begin
            side_ff[k].valid <= side_in[k].valid;
         end
      end
   end

   assign out_side = side_ff[N-1];
   assign out_quo  = side_ff[N-1].dbl ? (quo_ff[N-1] << 1) : quo_ff[N-1];

endmodule
`default_nettype wire

// ===== rtl/bsc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bsc_pkg::side_type in_side,
   input  wire logic [31:0]       in_quo,
   input  wire bsc_pkg::cal_type  cal,
   output logic                   out_valid,
   output bsc_pkg::rsp_type       out_item
);

   logic [31:0] p7, p8, p9;
   assign p7 = bsc_pkg::hi_s(cal.p6_p7);
   assign p8 = bsc_pkg::lo_s(cal.p8_p9);
   assign p9 = bsc_pkg::hi_s(cal.p8_p9);

   logic [bsc_pkg::BackDepth-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[bsc_pkg::BackDepth-2:0], in_side.valid};
      end
   end

   logic [31:0] p_ff [0:1];
   logic [31:0] temp_ff [0:1];
   logic        err_ff [0:1];
   logic [31:0] sqp_ff, bb_ff, x_ff, bs_ff;
   logic [31:0] pa;
   assign pa = in_quo >> 3;

   always_ff @(posedge clock) begin
      p_ff[0]    <= in_quo;
      temp_ff[0] <= in_side.temp;
      err_ff[0]  <= in_side.err;
      sqp_ff     <= pa * pa;
      bb_ff      <= (in_quo >> 2) * p8;
      p_ff[1]    <= p_ff[0];
      temp_ff[1] <= temp_ff[0];
      err_ff[1]  <= err_ff[0];
      x_ff       <= p9 * (sqp_ff >> 13);
      bs_ff      <= bsc_pkg::sra32(bb_ff, 5'd13);
   end

   bsc_pkg::rsp_type item_ff;
   logic [31:0] pf;
   assign pf = p_ff[1] + bsc_pkg::sra32(bsc_pkg::sra32(x_ff, 5'd12) + bs_ff + p7, 5'd4);

   always_ff @(posedge clock) begin
      item_ff.temperature_centi <= temp_ff[1];
      item_ff.divide_error      <= err_ff[1];
      item_ff.pressure_pascal   <= err_ff[1] ? 32'd0 : pf;
   end

   assign out_valid = vld_ff[bsc_pkg::BackDepth-1];
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ===== rtl/baro_sensor_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from start to rsp_strobe: 10 front stages, 32 divider
// stages at one quotient bit each, 3 back stages.
// Throughput: one item per cycle; busy is never raised and results cannot
// be held off by the receiver.
// Reset: synchronous, clears the pipeline valid bits and the six calibration
// registers to zero.
module baro_sensor_compensation (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire bsc_pkg::req_type     req_item,
   output logic                      rsp_strobe,
   output bsc_pkg::rsp_type          rsp_item,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [bsc_pkg::AddrW-1:0] paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   bsc_pkg::cal_type cal_ff, cal_in;
   logic wr;
   assign wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign busy = 1'b0;

   always_comb begin
      cal_in = cal_ff;
      if (wr) begin
         unique case (paddr[4:2])
            bsc_pkg::REG_T1_T2: cal_in.t1_t2 = pwdata;
            bsc_pkg::REG_T3_P1: cal_in.t3_p1 = pwdata;
            bsc_pkg::REG_P2_P3: cal_in.p2_p3 = pwdata;
            bsc_pkg::REG_P4_P5: cal_in.p4_p5 = pwdata;
            bsc_pkg::REG_P6_P7: cal_in.p6_p7 = pwdata;
            bsc_pkg::REG_P8_P9: cal_in.p8_p9 = pwdata;
            default: cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         bsc_pkg::REG_T1_T2: prdata = cal_ff.t1_t2;
         bsc_pkg::REG_T3_P1: prdata = cal_ff.t3_p1;
         bsc_pkg::REG_P2_P3: prdata = cal_ff.p2_p3;
         bsc_pkg::REG_P4_P5: prdata = cal_ff.p4_p5;
         bsc_pkg::REG_P6_P7: prdata = cal_ff.p6_p7;
         bsc_pkg::REG_P8_P9: prdata = cal_ff.p8_p9;
         default: prdata = 32'd0;
      endcase
   end

   logic f_valid;
   logic [31:0] f_num, f_div, f_temp;

   bsc_front u_front (
      .clock, .reset,
      .in_valid (start && !busy),
      .in_item  (req_item),
      .cal      (cal_ff),
      .out_valid(f_valid),
      .out_num  (f_num),
      .out_div  (f_div),
      .out_temp (f_temp)
   );

   bsc_pkg::side_type d_side;
   logic [31:0] d_quo;

   bsc_div u_div (
      .clock, .reset,
      .in_valid(f_valid),
      .in_num  (f_num),
      .in_div  (f_div),
      .in_temp (f_temp),
      .out_side(d_side),
      .out_quo (d_quo)
   );

   bsc_back u_back (
      .clock, .reset,
      .in_side  (d_side),
      .in_quo   (d_quo),
      .cal      (cal_ff),
      .out_valid(rsp_strobe),
      .out_item (rsp_item)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.divide_error |-> rsp_item.pressure_pascal == 32'd0)
      else $error("divide error item with nonzero pressure");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 45))
      else $error("result without matching start");

   a_div_err: assert property (@(posedge clock) disable iff (reset)
      d_side.valid && d_side.err |-> ##3 rsp_strobe && rsp_item.divide_error)
      else $error("divide error lost in back stages");

endmodule
`default_nettype wire
